>>> sv/dvc_pkg.sv
// dvc_pkg: shared types and constants for the disk visibility count grid
// no dependencies
`default_nettype none
package dvc_pkg;

	localparam int MAX_COLS    = 64;
	localparam int MAX_ROWS    = 64;
	localparam int NUM_PLAYERS = 8;
	localparam int COUNT_BITS  = 8;

	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int PLY_W   = $clog2(NUM_PLAYERS);
	localparam int ADDR_W  = PLY_W + ROW_W + COL_W;
	localparam int RAM_DEPTH = NUM_PLAYERS * MAX_ROWS * MAX_COLS;

	localparam int GRID_W   = 7;
	localparam int RAD_W    = 4;
	localparam int OP_W     = 2;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [GRID_W-1:0] GRID_COLS_MAX = GRID_W'(MAX_COLS);
	localparam logic [GRID_W-1:0] GRID_ROWS_MAX = GRID_W'(MAX_ROWS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// config register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// opcodes
	localparam logic [OP_W-1:0] OP_REVEAL  = 2'd0;
	localparam logic [OP_W-1:0] OP_CONCEAL = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_ADD,
		CMD_SUB,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [PLY_W-1:0]  player;
		logic [RAD_W-1:0]  rad;
		logic [COL_W-1:0]  x0;
		logic [ROW_W-1:0]  y0;
		logic [COL_W-1:0]  min_x;
		logic [COL_W-1:0]  max_x;
		logic [ROW_W-1:0]  min_y;
		logic [ROW_W-1:0]  max_y;
		logic              q_in0;
		logic              q_in1;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_WALK,
		BK_QA,
		BK_QB,
		BK_QC,
		BK_EMIT
	} bk_state_t;

endpackage
`default_nettype wire

>>> sv/dvc_ram.sv
// dvc_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module dvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> sv/dvc_queue.sv
// dvc_queue: short command queue between front and back
// depends on dvc_pkg
`default_nettype none
module dvc_queue import dvc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t din,
	output      logic full,
	input  wire logic pop,
	output      cmd_t dout,
	output      logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/dvc_front.sv
// dvc_front: accepts input transactions, clips the disk box and classifies them
// depends on dvc_pkg
`default_nettype none
module dvc_front import dvc_pkg::*; (
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [GRID_W-1:0]    grid_width,
	input  wire logic [GRID_W-1:0]    grid_height,
	input  wire logic                 q_full,
	input  wire logic                 clearing,
	output      logic                 push,
	output      cmd_t                 cmd
);

	logic [OP_W-1:0]   opcode;
	logic [PLY_W-1:0]  player_id;
	logic [RAD_W-1:0]  radius;
	logic [COL_W-1:0]  pos_x;
	logic [ROW_W-1:0]  pos_y;
	logic [GRID_W-1:0] cols;
	logic [GRID_W-1:0] rows;
	logic [GRID_W-1:0] hi_x_raw;
	logic [GRID_W-1:0] hi_y_raw;
	logic [GRID_W-1:0] hi_x;
	logic [GRID_W-1:0] hi_y;
	logic [COL_W-1:0]  lo_x;
	logic [ROW_W-1:0]  lo_y;
	logic              empty_box;
	logic [GRID_W-1:0] nx;
	logic [GRID_W-1:0] ny;

	assign opcode    = s_tdata[1:0];
	assign player_id = s_tdata[4:2];
	assign radius    = s_tdata[8:5];
	assign pos_x     = s_tdata[14:9];
	assign pos_y     = s_tdata[20:15];

	assign s_tready = !q_full && !clearing;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		cols = (grid_width > GRID_COLS_MAX) ? GRID_COLS_MAX : grid_width;
		rows = (grid_height > GRID_ROWS_MAX) ? GRID_ROWS_MAX : grid_height;

		lo_x = (pos_x >= COL_W'(radius)) ? pos_x - COL_W'(radius) : '0;
		lo_y = (pos_y >= ROW_W'(radius)) ? pos_y - ROW_W'(radius) : '0;
		hi_x_raw = GRID_W'(pos_x) + GRID_W'(radius);
		hi_y_raw = GRID_W'(pos_y) + GRID_W'(radius);
		hi_x = (hi_x_raw > cols - 1'b1) ? cols - 1'b1 : hi_x_raw;
		hi_y = (hi_y_raw > rows - 1'b1) ? rows - 1'b1 : hi_y_raw;
		empty_box = (cols == '0) || (rows == '0) ||
			(GRID_W'(lo_x) > hi_x) || (GRID_W'(lo_y) > hi_y);

		nx = GRID_W'(pos_x) + 1'b1;
		ny = GRID_W'(pos_y) + 1'b1;

		cmd.player = player_id;
		cmd.rad    = radius;
		cmd.x0     = pos_x;
		cmd.y0     = pos_y;
		cmd.min_x  = lo_x;
		cmd.min_y  = lo_y;
		cmd.max_x  = hi_x[COL_W-1:0];
		cmd.max_y  = hi_y[ROW_W-1:0];
		cmd.q_in0  = (GRID_W'(pos_x) < cols) && (GRID_W'(pos_y) < rows);
		cmd.q_in1  = (nx < cols) && (ny < rows);

		case (opcode)
			OP_REVEAL:  cmd.kind = (player_id != '0 && !empty_box) ? CMD_ADD : CMD_NOP;
			OP_CONCEAL: cmd.kind = (player_id != '0 && !empty_box) ? CMD_SUB : CMD_NOP;
			OP_QUERY:   cmd.kind = CMD_QUERY;
			default:    cmd.kind = CMD_NOP;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/dvc_back.sv
// dvc_back: clears the counter store, walks disk boxes, answers queries
// depends on dvc_pkg and dvc_ram
`default_nettype none
module dvc_back import dvc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 head,
	input  wire logic                 q_empty,
	output      logic                 pop,
	output      logic                 clearing,
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [M_TDATA_W-1:0] m_tdata
);

	bk_state_t state_q, state_nxt;
	cmd_t             cmd_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [COL_W-1:0] cx_q;
	logic [ROW_W-1:0] cy_q;
	logic             wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic             vis0_q;
	logic             vis_q;
	logic             out_valid_q;
	logic             out_vis_q;

	logic [ADDR_W-1:0]     walk_addr;
	logic [ADDR_W-1:0]     q0_addr;
	logic [ADDR_W-1:0]     q1_addr;
	logic [ADDR_W-1:0]     raddr;
	logic [COUNT_BITS-1:0] rdata;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [COL_W-1:0]      dx_full;
	logic [ROW_W-1:0]      dy_full;
	logic [RAD_W-1:0]      dx;
	logic [RAD_W-1:0]      dy;
	logic [2*RAD_W:0]      dist2;
	logic [2*RAD_W-1:0]    rad2;
	logic                  in_disk;
	logic                  walk_end;
	logic                  emit_go;

	assign walk_addr = {cmd_q.player, cy_q, cx_q};
	assign q0_addr   = {cmd_q.player, cmd_q.y0, cmd_q.x0};
	assign q1_addr   = {cmd_q.player, cmd_q.y0 + 1'b1, cmd_q.x0 + 1'b1};

	always_comb begin
		dx_full = (cx_q >= cmd_q.x0) ? cx_q - cmd_q.x0 : cmd_q.x0 - cx_q;
		dy_full = (cy_q >= cmd_q.y0) ? cy_q - cmd_q.y0 : cmd_q.y0 - cy_q;
		dx = dx_full[RAD_W-1:0];
		dy = dy_full[RAD_W-1:0];
		dist2 = (2*RAD_W+1)'((2*RAD_W)'(dx) * (2*RAD_W)'(dx)) +
			(2*RAD_W+1)'((2*RAD_W)'(dy) * (2*RAD_W)'(dy));
		rad2 = (2*RAD_W)'(cmd_q.rad) * (2*RAD_W)'(cmd_q.rad);
		in_disk = dist2 <= (2*RAD_W+1)'(rad2);
		walk_end = (cx_q == cmd_q.max_x) && (cy_q == cmd_q.max_y);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_CLEAR: if (clr_addr_q == {ADDR_W{1'b1}}) state_nxt = BK_IDLE;
			BK_IDLE: begin
				if (!q_empty) begin
					case (head.kind)
						CMD_ADD, CMD_SUB: state_nxt = BK_WALK;
						CMD_QUERY:        state_nxt = BK_QA;
						default:          state_nxt = BK_EMIT;
					endcase
				end
			end
			BK_WALK: if (walk_end) state_nxt = BK_EMIT;
			BK_QA:   state_nxt = BK_QB;
			BK_QB:   state_nxt = BK_QC;
			BK_QC:   state_nxt = BK_EMIT;
			BK_EMIT: if (emit_go) state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop      = 1'b0;
		clearing = 1'b0;
		raddr    = walk_addr;
		emit_go  = 1'b0;
		case (state_q)
			BK_CLEAR: clearing = 1'b1;
			BK_IDLE:  pop = !q_empty;
			BK_QA:    raddr = q0_addr;
			BK_QB:    raddr = q1_addr;
			BK_EMIT:  emit_go = !out_valid_q || m_tready;
			default:  ;
		endcase
	end

	always_comb begin
		if (state_q == BK_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr_pend_s1;
			waddr = wr_addr_s1;
			if (cmd_q.kind == CMD_ADD) begin
				wdata = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
			end else begin
				wdata = (rdata == '0) ? rdata : rdata - 1'b1;
			end
		end
	end

	dvc_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		wr_addr_s1 <= walk_addr;
		if (pop) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			wr_pend_s1  <= 1'b0;
			vis0_q      <= 1'b0;
			vis_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_vis_q   <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			wr_pend_s1 <= (state_q == BK_WALK) && in_disk;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (pop) begin
				cx_q  <= head.min_x;
				cy_q  <= head.min_y;
				vis_q <= 1'b0;
			end else if (state_q == BK_WALK) begin
				if (cx_q == cmd_q.max_x) begin
					cx_q <= cmd_q.min_x;
					cy_q <= cy_q + 1'b1;
				end else begin
					cx_q <= cx_q + 1'b1;
				end
			end
			if (state_q == BK_QB) begin
				vis0_q <= cmd_q.q_in0 && (rdata != '0);
			end
			if (state_q == BK_QC) begin
				vis_q <= vis0_q || (cmd_q.q_in1 && (rdata != '0));
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				out_vis_q   <= vis_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, out_vis_q};

endmodule
`default_nettype wire

>>> sv/disk_visibility_count_grid.sv
// disk_visibility_count_grid: top level, config registers, front, queue and back
// depends on dvc_pkg, dvc_front, dvc_queue, dvc_back
//
// per-player grids of saturating visibility counters
// slave stream: opcode (reveal, conceal, query), player, radius and position
// master stream: one result transaction per input transaction, in order;
// visible is the query answer, zero for every other opcode
// config port: cfg_we writes cfg_data into grid_width (index 0) or grid_height
// (index 1), taken at once; the user must write only while the block is idle,
// which the block itself does not enforce
// a reveal or conceal walks the clipped bounding box of the disk, one cell per
// cycle, with a read-modify-write of the counter ram for each cell in the disk;
// a query makes two ram reads; a no-op command goes straight to the emit step
// a two-entry command queue lets the front accept while the back works
// reset: the back zeroes all 32768 counter ram entries, one entry a cycle,
// with s_tready low; config writes are taken during it
// a stalled master side holds one result in the output register; the back
// then waits at its emit step and the queue fills before s_tready drops
`default_nettype none
module disk_visibility_count_grid import dvc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	// opcode[1:0], player_id[4:2], radius[8:5], pos_x[14:9], pos_y[20:15], zeros
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	// visible[0], zeros
	output      logic [M_TDATA_W-1:0] m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [GRID_W-1:0]    cfg_data
);

	logic [GRID_W-1:0] grid_width_q;
	logic [GRID_W-1:0] grid_height_q;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	logic              clearing;
	cmd_t              cmd_in;
	cmd_t              cmd_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_COLS_MAX;
			grid_height_q <= GRID_ROWS_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dvc_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.grid_width (grid_width_q),
		.grid_height(grid_height_q),
		.q_full     (q_full),
		.clearing   (clearing),
		.push       (push),
		.cmd        (cmd_in)
	);

	dvc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd_in),
		.full  (q_full),
		.pop   (pop),
		.dout  (cmd_head),
		.empty (q_empty)
	);

	dvc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (cmd_head),
		.q_empty (q_empty),
		.pop     (pop),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
`default_nettype wire
